// ===== hdl/lpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, constants and helper functions for the lidar point converter.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STAGE_STEPS  = 4;
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  localparam logic [17:0] MIN_RANGE_RST = 18'd200;
  localparam logic [17:0] MAX_RANGE_RST = 18'd200000;

  // APB register indexes (paddr[2])
  localparam logic REG_MIN_RANGE = 1'b0;
  localparam logic REG_MAX_RANGE = 1'b1;

  localparam logic REQ_POINT = 1'b0;
  localparam logic REQ_CAL   = 1'b1;

  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_1 = 2'd1;
  localparam quad_t QUAD_2 = 2'd2;
  localparam quad_t QUAD_3 = 2'd3;

  // rotation state: x, y in Q30, angle in 1/1024 centidegree
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [24:0] z;
  } cdc_t;

  function automatic logic [22:0] atan_step(input int i);
    logic [22:0] r;
    unique case (i)
      0:       r = 23'd4608000;
      1:       r = 23'd2720261;
      2:       r = 23'd1437311;
      3:       r = 23'd729602;
      4:       r = 23'd366217;
      5:       r = 23'd183287;
      6:       r = 23'd91666;
      7:       r = 23'd45836;
      8:       r = 23'd22918;
      9:       r = 23'd11459;
      10:      r = 23'd5730;
      11:      r = 23'd2865;
      12:      r = 23'd1432;
      13:      r = 23'd716;
      14:      r = 23'd358;
      15:      r = 23'd179;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // clamp to the 19-bit coordinate range
  function automatic logic signed [18:0] sat_coord(input logic signed [22:0] v);
    logic signed [18:0] r;
    if (v > 23'sd262143) begin
      r = 19'sd262143;
    end else if (v < -23'sd262144) begin
      r = -19'sd262144;
    end else begin
      r = v[18:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/lpc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_if
// Valid/ready channels for lidar request words and Cartesian point words.
// ----------------------------------------------------------------------------
interface lpc_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [6:0]         ring;
  logic [17:0]        distance_mm;
  logic [15:0]        azimuth_centideg;
  logic [62:0]        stamp_ns;
  logic [15:0]        return_strength;
  logic signed [15:0] cal_cosine;
  logic signed [15:0] cal_sine;

  modport source (output valid, req_type, ring, distance_mm, azimuth_centideg, stamp_ns,
                  return_strength, cal_cosine, cal_sine, input ready);
  modport sink (input valid, req_type, ring, distance_mm, azimuth_centideg, stamp_ns,
                return_strength, cal_cosine, cal_sine, output ready);
endinterface

interface lpc_pt_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] pos_x_mm;
  logic signed [18:0] pos_y_mm;
  logic signed [18:0] pos_z_mm;
  logic [6:0]         out_ring;
  logic [15:0]        out_strength;
  logic [62:0]        out_stamp_ns;
  logic               ring_uncalibrated;

  modport source (output valid, pos_x_mm, pos_y_mm, pos_z_mm, out_ring, out_strength,
                  out_stamp_ns, ring_uncalibrated, input ready);
  modport sink (input valid, pos_x_mm, pos_y_mm, pos_z_mm, out_ring, out_strength,
                out_stamp_ns, ring_uncalibrated, output ready);
endinterface

// ===== hdl/lpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/lpc_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_cordic
// Four rotation steps of the azimuth CORDIC, starting at FIRST_STEP.
// ----------------------------------------------------------------------------
module lpc_cordic #(
  parameter int FIRST_STEP = 0
) (
  input  lpc_pkg::cdc_t din,
  output lpc_pkg::cdc_t dout
);
  import lpc_pkg::*;

  always_comb begin
    cdc_t c;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [24:0] da;
    c = din;
    for (int k = 0; k < STAGE_STEPS; k++) begin
      dx = c.y >>> (FIRST_STEP + k);
      dy = c.x >>> (FIRST_STEP + k);
      da = $signed({2'b00, atan_step(FIRST_STEP + k)});
      if (!c.z[24]) begin
        c.x = c.x - dx;
        c.y = c.y + dy;
        c.z = c.z - da;
      end else begin
        c.x = c.x + dx;
        c.y = c.y - dy;
        c.z = c.z + da;
      end
    end
    dout = c;
  end
endmodule

// ===== hdl/lidar_point_to_cartesian.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_to_cartesian
// Lidar polar-to-Cartesian converter with per-ring elevation calibration.
// ----------------------------------------------------------------------------
// Path: an accepted request word passes the stage 1 to stage 7 registers, then the output register.
// Throughput: one word per cycle; the eight-stage pipeline moves as one and
//   freezes only while the output register holds a word not yet taken.
// Reset: clears pipeline valids, range registers (200 / 200000 mm) and the
//   per-ring calibration valid bits, so every ring reads as uncalibrated.
// ----------------------------------------------------------------------------
module lidar_point_to_cartesian #(
  parameter int RING_COUNT = 96
) (
  input  logic         clk,
  input  logic         rst,
  lpc_req_if.sink      req,
  lpc_pt_if.source     rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lpc_pkg::*;

  localparam int AW = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;

  // ---------------- configuration registers ----------------
  logic [17:0] min_range;
  logic [17:0] max_range;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_RANGE) ? {14'd0, max_range} : {14'd0, min_range};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range <= MIN_RANGE_RST;
      max_range <= MAX_RANGE_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MIN_RANGE) begin
        min_range <= pwdata[17:0];
      end else begin
        max_range <= pwdata[17:0];
      end
    end
  end

  // ---------------- global pipeline advance ----------------
  // Every stage moves together; output register stalls the whole line.
  logic adv;
  logic acc;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;
  assign acc       = req.valid && adv;

  // ---------------- stage 0: input decode ----------------
  logic        ring_ok;
  logic [AW-1:0] ring_idx;
  logic        keep;
  logic [15:0] az_mod;
  quad_t       quad0;
  logic [13:0] az_rem;

  assign ring_ok  = {25'd0, req.ring} < RING_COUNT;
  assign ring_idx = req.ring[AW-1:0];
  assign keep     = (req.req_type == REQ_POINT) &&
                    (req.distance_mm >= min_range) && (req.distance_mm <= max_range);

  // azimuth wrap into [0, 36000) and quadrant split
  always_comb begin
    logic [15:0] r;
    az_mod = (req.azimuth_centideg >= 16'd36000) ? req.azimuth_centideg - 16'd36000
                                                 : req.azimuth_centideg;
    if (az_mod >= 16'd27000) begin
      quad0 = QUAD_3;
      r     = az_mod - 16'd27000;
    end else if (az_mod >= 16'd18000) begin
      quad0 = QUAD_2;
      r     = az_mod - 16'd18000;
    end else if (az_mod >= 16'd9000) begin
      quad0 = QUAD_1;
      r     = az_mod - 16'd9000;
    end else begin
      quad0 = QUAD_0;
      r     = az_mod;
    end
    az_rem = r[13:0];
  end

  // calibration table; valid bits stand in for the reset clear
  logic             cal_we;
  logic [31:0]      cal_rdata;
  logic [RING_COUNT-1:0] cal_vld;

  assign cal_we = acc && (req.req_type == REQ_CAL) && ring_ok;

  lpc_ram #(.WIDTH(32), .DEPTH(RING_COUNT)) u_cal_ram (
    .clk   (clk),
    .we    (cal_we),
    .waddr (ring_idx),
    .wdata ({req.cal_cosine, req.cal_sine}),
    .re    (adv),
    .raddr (ring_idx),
    .rdata (cal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_vld <= '0;
    end else if (cal_we) begin
      cal_vld[ring_idx] <= 1'b1;
    end
  end

  // ---------------- stage 1: table read, angle seed, rotation steps 0-3 ----------------
  logic        s1_valid;
  logic        s1_cal_ok;
  logic [6:0]  s1_ring;
  logic [17:0] s1_dist;
  logic [62:0] s1_stamp;
  logic [15:0] s1_str;
  quad_t       s1_quad;
  logic [13:0] s1_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cal_ok <= ring_ok && cal_vld[ring_idx];
      s1_ring   <= req.ring;
      s1_dist   <= req.distance_mm;
      s1_stamp  <= req.stamp_ns;
      s1_str    <= req.return_strength;
      s1_quad   <= quad0;
      s1_rem    <= az_rem;
    end
  end

  logic signed [15:0] s1_ce;
  logic signed [15:0] s1_se;
  cdc_t               s1_cdc;
  cdc_t               s1_cdc_out;

  assign s1_ce = s1_cal_ok ? $signed(cal_rdata[31:16]) : 16'sd0;
  assign s1_se = s1_cal_ok ? $signed(cal_rdata[15:0])  : 16'sd0;

  assign s1_cdc.x = CORDIC_GAIN_Q30;
  assign s1_cdc.y = 33'sd0;
  assign s1_cdc.z = $signed({1'b0, s1_rem, 10'd0});

  lpc_cordic #(.FIRST_STEP(0)) u_cordic_0 (
    .din  (s1_cdc),
    .dout (s1_cdc_out)
  );

  // ---------------- stage 2: elevation products, rotation steps 4-7 ----------------
  logic               s2_valid;
  logic               s2_flag;
  logic signed [34:0] s2_dc;
  logic signed [34:0] s2_ds;
  cdc_t               s2_cdc;
  quad_t              s2_quad;
  logic [6:0]         s2_ring;
  logic [62:0]        s2_stamp;
  logic [15:0]        s2_str;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_flag  <= (s1_ce == 16'sd0);
      s2_dc    <= $signed({17'd0, s1_dist}) * 35'(s1_ce);
      s2_ds    <= $signed({17'd0, s1_dist}) * 35'(s1_se);
      s2_cdc   <= s1_cdc_out;
      s2_quad  <= s1_quad;
      s2_ring  <= s1_ring;
      s2_stamp <= s1_stamp;
      s2_str   <= s1_str;
    end
  end

  cdc_t s2_cdc_out;

  lpc_cordic #(.FIRST_STEP(STAGE_STEPS)) u_cordic_1 (
    .din  (s2_cdc),
    .dout (s2_cdc_out)
  );

  // ---------------- stage 3: rotation steps 8-11 ----------------
  logic               s3_valid;
  logic               s3_flag;
  logic signed [34:0] s3_dc;
  logic signed [34:0] s3_ds;
  cdc_t               s3_cdc;
  quad_t              s3_quad;
  logic [6:0]         s3_ring;
  logic [62:0]        s3_stamp;
  logic [15:0]        s3_str;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_flag  <= s2_flag;
      s3_dc    <= s2_dc;
      s3_ds    <= s2_ds;
      s3_cdc   <= s2_cdc_out;
      s3_quad  <= s2_quad;
      s3_ring  <= s2_ring;
      s3_stamp <= s2_stamp;
      s3_str   <= s2_str;
    end
  end

  cdc_t s3_cdc_out;

  lpc_cordic #(.FIRST_STEP(2 * STAGE_STEPS)) u_cordic_2 (
    .din  (s3_cdc),
    .dout (s3_cdc_out)
  );

  // ---------------- stage 4: rotation steps 12-15 ----------------
  logic               s4_valid;
  logic               s4_flag;
  logic signed [34:0] s4_dc;
  logic signed [34:0] s4_ds;
  cdc_t               s4_cdc;
  quad_t              s4_quad;
  logic [6:0]         s4_ring;
  logic [62:0]        s4_stamp;
  logic [15:0]        s4_str;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_flag  <= s3_flag;
      s4_dc    <= s3_dc;
      s4_ds    <= s3_ds;
      s4_cdc   <= s3_cdc_out;
      s4_quad  <= s3_quad;
      s4_ring  <= s3_ring;
      s4_stamp <= s3_stamp;
      s4_str   <= s3_str;
    end
  end

  cdc_t s4_cdc_out;

  lpc_cordic #(.FIRST_STEP(3 * STAGE_STEPS)) u_cordic_3 (
    .din  (s4_cdc),
    .dout (s4_cdc_out)
  );

  // ---------------- stage 5: rotation done ----------------
  logic               s5_valid;
  logic               s5_flag;
  logic signed [34:0] s5_dc;
  logic signed [34:0] s5_ds;
  logic signed [32:0] s5_x;
  logic signed [32:0] s5_y;
  quad_t              s5_quad;
  logic [6:0]         s5_ring;
  logic [62:0]        s5_stamp;
  logic [15:0]        s5_str;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_flag  <= s4_flag;
      s5_dc    <= s4_dc;
      s5_ds    <= s4_ds;
      s5_x     <= s4_cdc_out.x;
      s5_y     <= s4_cdc_out.y;
      s5_quad  <= s4_quad;
      s5_ring  <= s4_ring;
      s5_stamp <= s4_stamp;
      s5_str   <= s4_str;
    end
  end

  // Q30 -> Q15 rounding, then quadrant mapping
  logic signed [32:0] c_rnd;
  logic signed [32:0] s_rnd;
  logic signed [17:0] c15;
  logic signed [17:0] s15;
  logic signed [17:0] ca;
  logic signed [17:0] sa;

  assign c_rnd = (s5_x + 33'sd16384) >>> 15;
  assign s_rnd = (s5_y + 33'sd16384) >>> 15;
  assign c15   = c_rnd[17:0];
  assign s15   = s_rnd[17:0];

  always_comb begin
    unique case (s5_quad)
      QUAD_0: begin ca = c15;  sa = s15;  end
      QUAD_1: begin ca = -s15; sa = c15;  end
      QUAD_2: begin ca = -c15; sa = -s15; end
      QUAD_3: begin ca = s15;  sa = -c15; end
      default: begin ca = c15; sa = s15;  end
    endcase
  end

  // ---------------- stage 6: azimuth sine/cosine, z ----------------
  logic               s6_valid;
  logic               s6_flag;
  logic signed [34:0] s6_dc;
  logic signed [17:0] s6_ca;
  logic signed [17:0] s6_sa;
  logic signed [18:0] s6_z;
  logic [6:0]         s6_ring;
  logic [62:0]        s6_stamp;
  logic [15:0]        s6_str;
  logic signed [34:0] z_rnd;

  // z stays within 20 signed bits, so the low 23 bits keep its sign
  assign z_rnd = (s5_ds + 35'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_flag  <= s5_flag;
      s6_dc    <= s5_dc;
      s6_ca    <= ca;
      s6_sa    <= sa;
      s6_z     <= sat_coord(z_rnd[22:0]);
      s6_ring  <= s5_ring;
      s6_stamp <= s5_stamp;
      s6_str   <= s5_str;
    end
  end

  // ---------------- stage 7: horizontal products ----------------
  logic               s7_valid;
  logic               s7_flag;
  logic signed [52:0] s7_px;
  logic signed [52:0] s7_py;
  logic signed [18:0] s7_z;
  logic [6:0]         s7_ring;
  logic [62:0]        s7_stamp;
  logic [15:0]        s7_str;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (adv) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_flag  <= s6_flag;
      s7_px    <= 53'(s6_dc) * 53'(s6_ca);
      s7_py    <= 53'(s6_dc) * 53'(s6_sa);
      s7_z     <= s6_z;
      s7_ring  <= s6_ring;
      s7_stamp <= s6_stamp;
      s7_str   <= s6_str;
    end
  end

  // Q30 -> mm, half up
  logic signed [52:0] x_rnd;
  logic signed [52:0] y_rnd;
  assign x_rnd = (s7_px + 53'sd536870912) >>> 30;
  assign y_rnd = (s7_py + 53'sd536870912) >>> 30;

  // ---------------- stage 8: output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.pos_x_mm          <= s7_flag ? 19'sd0 : sat_coord(x_rnd[22:0]);
      rsp.pos_y_mm          <= s7_flag ? 19'sd0 : sat_coord(y_rnd[22:0]);
      rsp.pos_z_mm          <= s7_flag ? 19'sd0 : s7_z;
      rsp.out_ring          <= s7_ring;
      rsp.out_strength      <= s7_str;
      rsp.out_stamp_ns      <= s7_stamp;
      rsp.ring_uncalibrated <= s7_flag;
    end
  end

  // ---------------- assertions ----------------
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ring_uncalibrated |->
      rsp.pos_x_mm == 19'sd0 && rsp.pos_y_mm == 19'sd0 && rsp.pos_z_mm == 19'sd0)
    else $error("uncalibrated point with nonzero coordinates");

  a_cal_no_word: assert property (@(posedge clk) disable iff (rst)
    acc && (req.req_type == REQ_CAL) |=> !s1_valid)
    else $error("calibration word entered the point pipeline");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp.valid && !s1_valid && !s7_valid)
    else $error("pipeline valid survived reset");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the lidar point converter against a cycle-free software model of
// its arithmetic. Calibration and point words are driven with random gaps,
// and point words are drained with random stalls. Every point word is
// compared field by field with the predicted Cartesian point.
// ----------------------------------------------------------------------------
module testbench;
  import lpc_pkg::*;

  localparam int RINGS = 96;
  localparam int MAX_CYCLES = 400000;

  typedef struct {
    logic        kind;
    logic [6:0]  ring;
    logic [17:0] range_mm;
    logic [15:0] azim;
    logic [62:0] stamp;
    logic [15:0] strength;
    logic [15:0] cosv;
    logic [15:0] sinv;
  } lidar_req_t;

  typedef struct packed {
    logic [18:0] x;
    logic [18:0] y;
    logic [18:0] z;
    logic [6:0]  ring;
    logic [15:0] strength;
    logic [62:0] stamp;
    logic        uncal;
  } cart_point_t;

  // --------------------------------------------------------------------------
  // Point predictor and store of expected Cartesian points
  // --------------------------------------------------------------------------
  class point_scoreboard;
    cart_point_t pending[$];
    logic signed [15:0] cos_tab[RINGS];
    logic signed [15:0] sin_tab[RINGS];
    logic [17:0] range_lo;
    logic [17:0] range_hi;
    int mismatches;
    int points_seen;
    int uncal_seen;
    int dropped;

    function new();
      foreach (cos_tab[i]) begin
        cos_tab[i] = '0;
        sin_tab[i] = '0;
      end
      range_lo = MIN_RANGE_RST;
      range_hi = MAX_RANGE_RST;
    endfunction

    function longint clamp19(longint v);
      if (v > 262143) return 262143;
      if (v < -262144) return -262144;
      return v;
    endfunction

    // quadrant-reduced rotation, Q30 inside, Q15 out
    function void azimuth_sincos(logic [15:0] cdeg, output longint c15,
                                 output longint s15);
      longint steps[16] = '{4608000, 2720261, 1437311, 729602, 366217, 183287,
                            91666, 45836, 22918, 11459, 5730, 2865, 1432, 716,
                            358, 179};
      int unsigned a;
      int unsigned quad;
      longint px, py, pz, dx, dy, c, s;
      a = cdeg % 36000;
      quad = a / 9000;
      px = 652032874;
      py = 0;
      pz = longint'(a % 9000) * 1024;
      for (int i = 0; i < 16; i++) begin
        dx = py >>> i;
        dy = px >>> i;
        if (pz >= 0) begin
          px -= dx; py += dy; pz -= steps[i];
        end else begin
          px += dx; py -= dy; pz += steps[i];
        end
      end
      c = (px + 16384) >>> 15;
      s = (py + 16384) >>> 15;
      case (quad)
        0: begin c15 = c;  s15 = s;  end
        1: begin c15 = -s; s15 = c;  end
        2: begin c15 = -c; s15 = -s; end
        default: begin c15 = s; s15 = -c; end
      endcase
    endfunction

    function void note_request(lidar_req_t r);
      cart_point_t p;
      longint ce, se, ca, sa, dc;
      if (r.kind == REQ_CAL) begin
        if (r.ring < RINGS) begin
          cos_tab[r.ring] = r.cosv;
          sin_tab[r.ring] = r.sinv;
        end
        return;
      end
      if (r.range_mm < range_lo || r.range_mm > range_hi) begin
        dropped++;
        return;
      end
      ce = 0;
      se = 0;
      if (r.ring < RINGS) begin
        ce = cos_tab[r.ring];
        se = sin_tab[r.ring];
      end
      p = '{default: '0};
      p.ring = r.ring;
      p.strength = r.strength;
      p.stamp = r.stamp;
      if (ce == 0) begin
        p.uncal = 1'b1;
      end else begin
        azimuth_sincos(r.azim, ca, sa);
        dc = longint'(r.range_mm) * ce;
        p.x = 19'(clamp19((dc * ca + (longint'(1) << 29)) >>> 30));
        p.y = 19'(clamp19((dc * sa + (longint'(1) << 29)) >>> 30));
        p.z = 19'(clamp19((longint'(r.range_mm) * se + 16384) >>> 15));
      end
      pending = {pending, p};
    endfunction

    function void check_point(cart_point_t got);
      cart_point_t want;
      points_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: point word with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.uncal) uncal_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: point mismatch exp x=%0d y=%0d z=%0d ring=%0d str=%0d t=%0h u=%0b",
                   $signed(want.x), $signed(want.y), $signed(want.z), want.ring,
                   want.strength, want.stamp, want.uncal,
                   "\n       got x=%0d y=%0d z=%0d ring=%0d str=%0d t=%0h u=%0b",
                   $signed(got.x), $signed(got.y), $signed(got.z), got.ring,
                   got.strength, got.stamp, got.uncal);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lpc_req_if req_ch();
  lpc_pt_if  pt_ch();

  lidar_point_to_cartesian i_dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(pt_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  point_scoreboard sb;
  int send_idle_pct;   // chance in 100 that the sender holds off a cycle
  int recv_stall_pct;  // chance in 100 that the receiver drops ready
  int cycles;
  int words_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit; far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: ready moves only at the falling edge
  always @(negedge clk) begin
    if (rst) pt_ch.ready <= 1'b0;
    else pt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result words are taken at the rising edge
  always @(posedge clk) begin
    cart_point_t got;
    if (!rst && pt_ch.valid && pt_ch.ready) begin
      got.x = pt_ch.pos_x_mm;
      got.y = pt_ch.pos_y_mm;
      got.z = pt_ch.pos_z_mm;
      got.ring = pt_ch.out_ring;
      got.strength = pt_ch.out_strength;
      got.stamp = pt_ch.out_stamp_ns;
      got.uncal = pt_ch.ring_uncalibrated;
      sb.check_point(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(lidar_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = r.kind;
    req_ch.ring = r.ring;
    req_ch.distance_mm = r.range_mm;
    req_ch.azimuth_centideg = r.azim;
    req_ch.stamp_ns = r.stamp;
    req_ch.return_strength = r.strength;
    req_ch.cal_cosine = r.cosv;
    req_ch.cal_sine = r.sinv;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
    words_sent++;
    @(negedge clk);
  endtask

  // wait for the pipeline to empty; dropped points may still be in flight
  task automatic drain();
    req_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic reg_write(logic addr_hi, logic [17:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {addr_hi, 2'b00};
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr_hi == REG_MIN_RANGE) sb.range_lo = value;
    else sb.range_hi = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic lidar_req_t cal_word(int ring, int c, int s);
    lidar_req_t r = '{default: '0};
    r.kind = REQ_CAL;
    r.ring = 7'(ring);
    r.cosv = 16'(c);
    r.sinv = 16'(s);
    r.range_mm = 18'($urandom);
    r.stamp = {$urandom, $urandom};
    return r;
  endfunction

  function automatic lidar_req_t point_word(int ring, int d, int az);
    lidar_req_t r;
    r.kind = REQ_POINT;
    r.ring = 7'(ring);
    r.range_mm = 18'(d);
    r.azim = 16'(az);
    r.stamp = {$urandom, $urandom};
    r.strength = 16'($urandom);
    r.cosv = 16'($urandom);
    r.sinv = 16'($urandom);
    return r;
  endfunction

  // Random words: mostly points on calibrated rings, some calibration
  // rewrites (including zero cosine and out-of-table rings) and stray rings.
  task automatic random_words(int count);
    lidar_req_t r;
    int d;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) begin
        r = cal_word($urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(RINGS - 1),
                     $urandom_range(7) == 0 ? 0 : $urandom, $urandom);
      end else begin
        case ($urandom_range(3))
          0: d = $urandom_range(262143);
          1: d = $urandom_range(2000);
          default: d = $urandom_range(sb.range_hi, sb.range_lo);
        endcase
        r = point_word($urandom_range(19) == 0 ? $urandom_range(127)
                                                : $urandom_range(RINGS - 1),
                       d, $urandom_range(5) == 0 ? $urandom_range(65535)
                                                 : $urandom_range(35999));
      end
      send_word(r);
    end
  endtask

  initial begin
    lidar_req_t r;
    sb = new();
    cycles = 0;
    words_sent = 0;
    send_idle_pct = 15;
    recv_stall_pct = 73;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_POINT;
    req_ch.ring = '0;
    req_ch.distance_mm = '0;
    req_ch.azimuth_centideg = '0;
    req_ch.stamp_ns = '0;
    req_ch.return_strength = '0;
    req_ch.cal_cosine = '0;
    req_ch.cal_sine = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset ranges, table empty, so early points are uncalibrated.
    send_word(point_word(3, 1000, 4500));
    send_word(point_word(0, 199, 0));        // just below minimum
    send_word(point_word(0, 200, 0));        // at minimum
    send_word(point_word(127, 200000, 0));   // ring beyond the table, at max
    send_word(point_word(0, 200001, 0));     // just above maximum
    send_word(cal_word(0, 32767, 0));
    send_word(cal_word(95, -32768, 32767));
    send_word(cal_word(5, 23170, -32768));
    send_word(cal_word(96, 1000, 1000));     // write past the table is ignored
    send_word(point_word(96, 5000, 100));
    send_word(point_word(0, 200000, 0));
    send_word(point_word(0, 100000, 8999));
    send_word(point_word(0, 100000, 9000));
    send_word(point_word(95, 200000, 18000));
    send_word(point_word(95, 150000, 27000));
    send_word(point_word(5, 120000, 35999));
    send_word(point_word(5, 120000, 36000));  // wraps to zero
    send_word(point_word(5, 199999, 65535));
    r = point_word(0, 300, 13500);
    r.stamp = '1;
    r.strength = '1;
    send_word(r);
    r.stamp = '0;
    r.strength = '0;
    send_word(r);
    send_word(cal_word(5, 0, 1234));         // cosine back to zero
    send_word(point_word(5, 1000, 100));
    drain();

    // Widest window: every distance passes and large values saturate.
    reg_write(REG_MIN_RANGE, 18'd0);
    reg_write(REG_MAX_RANGE, 18'd262143);
    send_word(point_word(95, 262143, 0));
    send_word(point_word(0, 0, 0));
    send_word(point_word(95, 262143, 9000));
    random_words(300);

    // Hold off until the pipe is empty, then resume.
    req_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    random_words(50);
    drain();

    send_idle_pct = 73;
    recv_stall_pct = 15;
    reg_write(REG_MIN_RANGE, 18'd1000);
    reg_write(REG_MAX_RANGE, 18'd150000);
    random_words(250);
    drain();

    // Minimum above maximum: every point is dropped.
    reg_write(REG_MIN_RANGE, 18'd262143);
    reg_write(REG_MAX_RANGE, 18'd0);
    random_words(30);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    reg_write(REG_MIN_RANGE, 18'd500);
    reg_write(REG_MAX_RANGE, 18'd500);
    send_word(point_word(0, 500, 4500));
    drain();
    reg_write(REG_MIN_RANGE, 18'd0);
    reg_write(REG_MAX_RANGE, 18'd262143);
    random_words(300);
    drain();

    $display("Sent %0d words over three idle patterns and six range settings.",
             words_sent);
    $display("Checked %0d points (%0d uncalibrated), %0d dropped by range, %0d mismatches.",
             sb.points_seen, sb.uncal_seen, sb.dropped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
